/* hdl/http_response_header_parser_defines.svh */
`ifndef HTTP_RESPONSE_HEADER_PARSER_DEFINES_SVH
`define HTTP_RESPONSE_HEADER_PARSER_DEFINES_SVH

// Same-cycle implication, checked on clk and masked during reset
`define HRHP_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked on clk and masked during reset
`define HRHP_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* hdl/hrhp_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
package hrhp_pkg;

	// Parser phase, also the reported parse state
	typedef enum logic [2:0] {
		PH_STATUS     = 3'd0,
		PH_HEADERS    = 3'd1,
		PH_DONE       = 3'd2,
		PH_BADLINE    = 3'd3,
		PH_UNACCEPTED = 3'd4,
		PH_NOLENGTH   = 3'd5
	} phase_t;

	// Progress through the value part of a length line
	typedef enum logic [1:0] {
		VP_IDLE   = 2'd0,
		VP_SKIP   = 2'd1,
		VP_DIGITS = 2'd2,
		VP_OTHER  = 2'd3
	} vphase_t;

	// Progress through a CR LF CR LF sequence
	typedef enum logic [1:0] {
		CRLF_NONE    = 2'd0,
		CRLF_CR      = 2'd1,
		CRLF_CRLF    = 2'd2,
		CRLF_CRLFCR  = 2'd3
	} crlf_t;

	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_COLON = 8'h3A;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;

	localparam logic [9:0] ACCEPTED_STATUS_RESET = 10'd200;

	localparam int NAME_LEN = 14;
	localparam int POS_W    = $clog2(NAME_LEN + 1);

	localparam logic [7:0] NAME_UPPER [NAME_LEN] = '{
		8'h43, 8'h4F, 8'h4E, 8'h54, 8'h45, 8'h4E, 8'h54,
		8'h2D, 8'h4C, 8'h45, 8'h4E, 8'h47, 8'h54, 8'h48};
	localparam logic [7:0] NAME_TITLE [NAME_LEN] = '{
		8'h43, 8'h6F, 8'h6E, 8'h74, 8'h65, 8'h6E, 8'h74,
		8'h2D, 8'h4C, 8'h65, 8'h6E, 8'h67, 8'h74, 8'h68};
	localparam logic [7:0] NAME_LOWER [NAME_LEN] = '{
		8'h63, 8'h6F, 8'h6E, 8'h74, 8'h65, 8'h6E, 8'h74,
		8'h2D, 8'h6C, 8'h65, 8'h6E, 8'h67, 8'h74, 8'h68};

	// Queue between front and back
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	// One classified byte
	typedef struct packed {
		logic [7:0] data;
		logic       first;
		logic       is_space;
		logic       is_colon;
		logic       is_cr;
		logic       is_lf;
		logic       is_digit;
		logic [3:0] digit;
	} item_t;

endpackage
`default_nettype wire

/* hdl/hrhp_front.sv */
`timescale 1ns / 1ps
`default_nettype none
module hrhp_front (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 s_tvalid,
	output logic                s_tready,
	input  wire  [7:0]          s_tdata,   // [7:0] rx_byte
	input  wire  [0:0]          s_tuser,   // [0] first_of_response
	output logic                q_wr_en,
	output hrhp_pkg::item_t     q_wr_item,
	input  wire                 q_wr_ready
);
	import hrhp_pkg::*;

	logic  vld_s1;
	item_t item_s1;
	item_t item_c;
	logic  load;

	// Classify the incoming byte
	always_comb begin
		item_c.data     = s_tdata;
		item_c.first    = s_tuser[0];
		item_c.is_space = (s_tdata == CH_SPACE);
		item_c.is_colon = (s_tdata == CH_COLON);
		item_c.is_cr    = (s_tdata == CH_CR);
		item_c.is_lf    = (s_tdata == CH_LF);
		item_c.is_digit = (s_tdata >= CH_ZERO) && (s_tdata <= CH_NINE);
		item_c.digit    = 4'(s_tdata - CH_ZERO);
	end

	assign s_tready  = !vld_s1 || q_wr_ready;
	assign load      = s_tvalid && s_tready;
	assign q_wr_en   = vld_s1 && q_wr_ready;
	assign q_wr_item = item_s1;

	// Hold the classified byte until the queue takes it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (load) begin
			vld_s1 <= 1'b1;
		end else if (q_wr_en) begin
			vld_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			item_s1 <= item_c;
		end
	end

endmodule
`default_nettype wire

/* hdl/hrhp_queue.sv */
`timescale 1ns / 1ps
`default_nettype none
module hrhp_queue (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 wr_en,
	input  hrhp_pkg::item_t     wr_item,
	output logic                wr_ready,
	input  wire                 rd_en,
	output hrhp_pkg::item_t     rd_item,
	output logic                rd_valid
);
	import hrhp_pkg::*;

	`include "http_response_header_parser_defines.svh"

	item_t              slot_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0]  wr_ptr_q;
	logic [QPTR_W-1:0]  rd_ptr_q;
	logic [QCNT_W-1:0]  count_q;
	logic               push;
	logic               pop;

	assign wr_ready = (count_q != QCNT_W'(QUEUE_DEPTH));
	assign rd_valid = (count_q != '0);
	assign rd_item  = slot_q[rd_ptr_q];
	assign push     = wr_en && wr_ready;
	assign pop      = rd_en && rd_valid;

	// Advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// Store the entry
	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= wr_item;
		end
	end

	`HRHP_ASSERT_IMP(a_count_bound, 1'b1, count_q <= QCNT_W'(QUEUE_DEPTH), "queue overfilled")
	`HRHP_ASSERT_NEXT(a_push_grows, push && !pop, count_q == $past(count_q) + 1'b1, "push lost")
	`HRHP_ASSERT_NEXT(a_pop_shrinks, pop && !push, count_q == $past(count_q) - 1'b1, "pop lost")

endmodule
`default_nettype wire

/* hdl/hrhp_back.sv */
`timescale 1ns / 1ps
`default_nettype none
module hrhp_back #(
	parameter int HEADER_COUNT_BITS = 16
) (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 cfg_wr_en,
	input  wire  [9:0]          cfg_wr_data,
	input  hrhp_pkg::item_t     rd_item,
	input  wire                 rd_valid,
	output logic                rd_en,
	output logic                m_tvalid,
	input  wire                 m_tready,
	output logic [63:0]         m_tdata,
	output logic [0:0]          m_tuser
);
	import hrhp_pkg::*;

	`include "http_response_header_parser_defines.svh"

	localparam int CNT_W = HEADER_COUNT_BITS;

	// Parser state
	logic [9:0]        accepted_q;
	phase_t            phase_q;
	logic [1:0]        space_q;
	logic [1:0]        code_chars_q;
	logic [9:0]        code_value_q;
	logic              code_open_q;
	logic [POS_W-1:0]  line_pos_q;
	logic [2:0]        alive_q;
	vphase_t           vphase_q;
	logic [31:0]       length_q;
	logic              seen_q;
	crlf_t             crlf_q;
	logic [CNT_W-1:0]  count_q;

	// Next state
	phase_t            ph;
	logic [1:0]        sc;
	logic [1:0]        cc;
	logic [9:0]        cv;
	logic              cdo;
	logic [POS_W-1:0]  lp;
	logic [2:0]        va;
	vphase_t           vp;
	logic [31:0]       lv;
	logic              ls;
	crlf_t             cr;
	logic [CNT_W-1:0]  bc;
	logic              body;
	logic [15:0]       hlen;
	logic              pos_zero;
	logic              line_end;
	logic              head_end;
	logic [35:0]       acc;
	logic [32:0]       cnt_ext;
	logic [3:0]        idx;

	// Output register
	phase_t            out_phase_q;
	logic [9:0]        out_code_q;
	logic [31:0]       out_len_q;
	logic [15:0]       out_hlen_q;
	logic              out_body_q;

	assign rd_en = rd_valid && (!m_tvalid || m_tready);

	// Step the parser by one byte
	always_comb begin
		if (rd_item.first) begin
			ph  = PH_STATUS;
			sc  = '0;
			cc  = '0;
			cv  = '0;
			cdo = 1'b1;
			lp  = '0;
			va  = 3'b111;
			vp  = VP_IDLE;
			lv  = '0;
			ls  = 1'b0;
			cr  = CRLF_NONE;
			bc  = '0;
		end else begin
			ph  = phase_q;
			sc  = space_q;
			cc  = code_chars_q;
			cv  = code_value_q;
			cdo = code_open_q;
			lp  = line_pos_q;
			va  = alive_q;
			vp  = vphase_q;
			lv  = length_q;
			ls  = seen_q;
			cr  = crlf_q;
			bc  = count_q;
		end
		body     = 1'b0;
		pos_zero = (bc == '0);
		line_end = rd_item.is_lf && (cr == CRLF_CR || cr == CRLF_CRLFCR);
		head_end = rd_item.is_lf && (cr == CRLF_CRLFCR);
		acc      = ({4'b0, lv} << 3) + ({4'b0, lv} << 1) + {32'b0, rd_item.digit};
		idx      = 4'(lp);

		if (ph == PH_DONE) begin
			body = 1'b1;
		end else if (ph == PH_STATUS || ph == PH_HEADERS) begin
			if (bc != '1) begin
				bc = bc + 1'b1;
			end

			// Track CR LF CR LF
			if (rd_item.is_cr) begin
				cr = (cr == CRLF_CRLF) ? CRLF_CRLFCR : CRLF_CR;
			end else if (rd_item.is_lf && cr == CRLF_CR) begin
				cr = CRLF_CRLF;
			end else begin
				cr = CRLF_NONE;
			end

			// Status line: code between the first two spaces
			if (ph == PH_STATUS) begin
				if (rd_item.is_space) begin
					if (sc == 2'd0) begin
						if (pos_zero) begin
							ph = PH_BADLINE;
						end else begin
							sc = 2'd1;
						end
					end else begin
						sc = 2'd2;
						if (cc != 2'd3) begin
							ph = PH_BADLINE;
						end else if (cv == accepted_q) begin
							ph = PH_HEADERS;
						end else begin
							ph = PH_UNACCEPTED;
						end
					end
				end else if (sc == 2'd1) begin
					if (cc == 2'd3) begin
						ph = PH_BADLINE;
					end else begin
						cc = cc + 1'b1;
						if (cdo && rd_item.is_digit) begin
							cv = {cv[6:0], 3'b0} + {cv[8:0], 1'b0} + {6'b0, rd_item.digit};
						end else begin
							cdo = 1'b0;
						end
					end
				end
			end

			// Header line: name match and length value
			if (line_end) begin
				lp = '0;
				va = 3'b111;
				vp = VP_IDLE;
			end else if (lp < POS_W'(NAME_LEN)) begin
				if (rd_item.data != NAME_UPPER[idx]) va[0] = 1'b0;
				if (rd_item.data != NAME_TITLE[idx]) va[1] = 1'b0;
				if (rd_item.data != NAME_LOWER[idx]) va[2] = 1'b0;
				lp = lp + 1'b1;
				if (lp == POS_W'(NAME_LEN) && va != 3'b000) begin
					lv = '0;
					ls = 1'b1;
					vp = VP_SKIP;
				end
			end else begin
				if (vp == VP_SKIP && !(rd_item.is_colon || rd_item.is_space)) begin
					vp = rd_item.is_digit ? VP_DIGITS : VP_OTHER;
				end
				if (vp == VP_DIGITS) begin
					if (rd_item.is_digit) begin
						lv = (acc[35:32] != 4'd0) ? 32'hFFFF_FFFF : acc[31:0];
					end else begin
						vp = VP_OTHER;
					end
				end
			end

			// Blank line ends the header
			if (head_end) begin
				if (ph == PH_STATUS) begin
					ph = PH_BADLINE;
				end else if (ph == PH_HEADERS) begin
					ph = ls ? PH_DONE : PH_NOLENGTH;
				end
			end
		end

		cnt_ext = 33'(bc);
		if (ph == PH_DONE) begin
			hlen = (cnt_ext > 33'h0_FFFF) ? 16'hFFFF : cnt_ext[15:0];
		end else begin
			hlen = '0;
		end
	end

	// Advance parser state and hold the configured status
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			accepted_q   <= ACCEPTED_STATUS_RESET;
			phase_q      <= PH_STATUS;
			space_q      <= '0;
			code_chars_q <= '0;
			code_value_q <= '0;
			code_open_q  <= 1'b1;
			line_pos_q   <= '0;
			alive_q      <= 3'b111;
			vphase_q     <= VP_IDLE;
			length_q     <= '0;
			seen_q       <= 1'b0;
			crlf_q       <= CRLF_NONE;
			count_q      <= '0;
			m_tvalid     <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				accepted_q <= cfg_wr_data;
			end
			if (rd_en) begin
				phase_q      <= ph;
				space_q      <= sc;
				code_chars_q <= cc;
				code_value_q <= cv;
				code_open_q  <= cdo;
				line_pos_q   <= lp;
				alive_q      <= va;
				vphase_q     <= vp;
				length_q     <= lv;
				seen_q       <= ls;
				crlf_q       <= cr;
				count_q      <= bc;
				m_tvalid     <= 1'b1;
			end else if (m_tready) begin
				m_tvalid <= 1'b0;
			end
		end
	end

	// Load the result register
	always_ff @(posedge clk) begin
		if (rd_en) begin
			out_phase_q <= ph;
			out_code_q  <= cv;
			out_len_q   <= lv;
			out_hlen_q  <= hlen;
			out_body_q  <= body;
		end
	end

	assign m_tdata = {3'b0, out_hlen_q, out_len_q, out_code_q, out_phase_q};
	assign m_tuser = out_body_q;

	`HRHP_ASSERT_IMP(a_body_done, m_tvalid && out_body_q, out_phase_q == PH_DONE, "body early")
	`HRHP_ASSERT_IMP(a_hlen_done, m_tvalid && out_hlen_q != 16'd0, out_phase_q == PH_DONE, "bad hlen")
	`HRHP_ASSERT_NEXT(a_done_holds, rd_en && !rd_item.first && phase_q == PH_DONE,
		phase_q == PH_DONE, "done state left")

endmodule
`default_nettype wire

/* hdl/http_response_header_parser.sv */
// Path: each byte passes through the front register, the queue and the back end's result register.
// Throughput: one byte per cycle when the output is not stalled; a four-entry queue lets input and output stall apart.
// The back end computes the per-byte parser state update combinationally and registers it.
// Reset (arst_n low, asynchronous): parser to status-line phase, queue empty,
// accepted status to 200.
`timescale 1ns / 1ps
`default_nettype none
module http_response_header_parser #(
	parameter int HEADER_COUNT_BITS = 16
) (
	input  wire          clk,
	input  wire          arst_n,
	input  wire          cfg_wr_en,
	input  wire  [9:0]   cfg_wr_data,  // accepted_status
	input  wire          s_tvalid,
	output logic         s_tready,
	input  wire  [7:0]   s_tdata,      // [7:0] rx_byte
	input  wire  [0:0]   s_tuser,      // [0] first_of_response
	output logic         m_tvalid,
	input  wire          m_tready,
	output logic [63:0]  m_tdata,      // [2:0] parse_state, [12:3] resp_code,
	                                   // [44:13] content_length, [60:45] header_length
	output logic [0:0]   m_tuser       // [0] body_byte
);
	import hrhp_pkg::*;

	logic  q_wr_en;
	logic  q_wr_ready;
	item_t q_wr_item;
	item_t q_rd_item;
	logic  q_rd_valid;
	logic  q_rd_en;

	hrhp_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tuser    (s_tuser),
		.q_wr_en    (q_wr_en),
		.q_wr_item  (q_wr_item),
		.q_wr_ready (q_wr_ready)
	);

	hrhp_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (q_wr_en),
		.wr_item  (q_wr_item),
		.wr_ready (q_wr_ready),
		.rd_en    (q_rd_en),
		.rd_item  (q_rd_item),
		.rd_valid (q_rd_valid)
	);

	hrhp_back #(
		.HEADER_COUNT_BITS (HEADER_COUNT_BITS)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.rd_item     (q_rd_item),
		.rd_valid    (q_rd_valid),
		.rd_en       (q_rd_en),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata),
		.m_tuser     (m_tuser)
	);

endmodule
`default_nettype wire

/* dv/tb_http_response_header_parser.sv */
`timescale 1ns / 1ps
module tb_http_response_header_parser;
	import hrhp_pkg::*;

	localparam int COUNT_BITS   = 16;
	localparam int CYCLE_LIMIT  = 2000000;
	localparam int RANDOM_BYTES = 700;

	// One per-byte report of the parser
	typedef struct {
		phase_t      state;
		logic [9:0]  code;
		logic [31:0] content_len;
		logic [15:0] hdr_bytes;
		logic        body;
	} parser_report_t;

	logic        clk         = 1'b0;
	logic        arst_n      = 1'b0;
	logic        cfg_wr_en   = 1'b0;
	logic [9:0]  cfg_wr_data = '0;
	logic        s_tvalid    = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata     = '0;
	logic [0:0]  s_tuser     = '0;
	logic        m_tvalid;
	logic        m_tready    = 1'b0;
	logic [63:0] m_tdata;
	logic [0:0]  m_tuser;

	http_response_header_parser #(
		.HEADER_COUNT_BITS(COUNT_BITS)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser)
	);

	always #5 clk = ~clk;

	// Expected parser reports, oldest first
	parser_report_t pending_reports[$];
	// Bytes of the response being built
	logic [7:0]     stream_q[$];
	int             mismatch_count = 0;
	int             cycle_count    = 0;
	bit             no_idle        = 1'b0;

	string length_names [3] = '{"CONTENT-LENGTH", "Content-Length", "content-length"};
	string other_names [4]  = '{"Content-Type", "Host", "Server", "X"};

	// Parser state as the block should hold it
	logic [9:0]            accepted_code = ACCEPTED_STATUS_RESET;
	phase_t                ph;
	logic [1:0]            space_seen;
	logic [2:0]            code_chars;
	logic [9:0]            code_val;
	logic                  code_open;
	logic [4:0]            line_pos;
	logic [2:0]            variant_alive;
	vphase_t               value_ph;
	logic [31:0]           length_val;
	logic                  length_seen;
	crlf_t                 crlf_ph;
	logic [COUNT_BITS-1:0] bytes_taken;

	function automatic void clear_parser();
		ph            = PH_STATUS;
		space_seen    = '0;
		code_chars    = '0;
		code_val      = '0;
		code_open     = 1'b1;
		line_pos      = '0;
		variant_alive = '1;
		value_ph      = VP_IDLE;
		length_val    = '0;
		length_seen   = 1'b0;
		crlf_ph       = CRLF_NONE;
		bytes_taken   = '0;
	endfunction

	// Take one byte and return the report the block should give for it
	function automatic parser_report_t advance_parser(logic [7:0] b, logic first);
		parser_report_t r;
		logic           at_start;
		logic           line_end;
		logic           head_end;
		logic           is_dig;
		logic [3:0]     d;
		logic [63:0]    acc;
		crlf_t          prev;
		if (first) clear_parser();
		is_dig        = (b >= CH_ZERO) && (b <= CH_NINE);
		d             = b[3:0];
		r.body        = 1'b0;
		r.hdr_bytes   = '0;
		if (ph == PH_DONE) begin
			r.body = 1'b1;
		end else if (ph == PH_STATUS || ph == PH_HEADERS) begin
			at_start = (bytes_taken == '0);
			prev     = crlf_ph;
			line_end = (b == CH_LF) && (prev == CRLF_CR || prev == CRLF_CRLFCR);
			head_end = (b == CH_LF) && (prev == CRLF_CRLFCR);
			if (bytes_taken != '1) bytes_taken++;

			// advance the CR LF CR LF tracker
			if (b == CH_CR) crlf_ph = (prev == CRLF_CRLF) ? CRLF_CRLFCR : CRLF_CR;
			else if (b == CH_LF && prev == CRLF_CR) crlf_ph = CRLF_CRLF;
			else crlf_ph = CRLF_NONE;

			// collect the code between the first two spaces
			if (ph == PH_STATUS) begin
				if (b == CH_SPACE) begin
					if (space_seen == 2'd0) begin
						if (at_start) ph = PH_BADLINE;
						else space_seen = 2'd1;
					end else begin
						space_seen = 2'd2;
						if (code_chars != 3'd3) ph = PH_BADLINE;
						else if (code_val == accepted_code) ph = PH_HEADERS;
						else ph = PH_UNACCEPTED;
					end
				end else if (space_seen == 2'd1) begin
					if (code_chars >= 3'd3) begin
						ph = PH_BADLINE;
					end else begin
						code_chars++;
						if (code_open && is_dig) code_val = code_val * 10'd10 + 10'(d);
						else code_open = 1'b0;
					end
				end
			end

			// match the length name, then skip separators and read digits
			if (line_end) begin
				line_pos      = '0;
				variant_alive = '1;
				value_ph      = VP_IDLE;
			end else if (line_pos < NAME_LEN) begin
				for (int k = 0; k < 3; k++)
					if (b != length_names[k][line_pos]) variant_alive[k] = 1'b0;
				line_pos++;
				if (line_pos == NAME_LEN && variant_alive != '0) begin
					length_val  = '0;
					length_seen = 1'b1;
					value_ph    = VP_SKIP;
				end
			end else if (value_ph == VP_SKIP && (b == CH_COLON || b == CH_SPACE)) begin
				value_ph = VP_SKIP;
			end else if (value_ph == VP_SKIP || value_ph == VP_DIGITS) begin
				if (is_dig) begin
					value_ph   = VP_DIGITS;
					acc        = 64'(length_val) * 64'd10 + 64'(d);
					length_val = (acc > 64'hFFFF_FFFF) ? '1 : acc[31:0];
				end else begin
					value_ph = VP_OTHER;
				end
			end

			// close the header on the blank line
			if (head_end) begin
				if (ph == PH_STATUS) ph = PH_BADLINE;
				else if (ph == PH_HEADERS) ph = length_seen ? PH_DONE : PH_NOLENGTH;
			end
		end
		if (ph == PH_DONE) r.hdr_bytes = bytes_taken;
		r.state       = ph;
		r.code        = code_val;
		r.content_len = length_val;
		return r;
	endfunction

	task automatic flag_mismatch(string field, logic [31:0] got, logic [31:0] want);
		if (mismatch_count < 50)
			$display("MISMATCH at %0t: %s got 0x%0h expected 0x%0h", $time, field, got, want);
		mismatch_count++;
	endtask

	// Predict each accepted request and check each accepted result
	always @(posedge clk) begin : scoreboard
		parser_report_t want;
		if (arst_n) begin
			if (s_tvalid && s_tready)
				pending_reports.push_back(advance_parser(s_tdata, s_tuser[0]));
			if (m_tvalid && m_tready) begin
				if (pending_reports.size() == 0) begin
					flag_mismatch("result with no request", m_tdata[31:0], '0);
				end else begin
					want = pending_reports.pop_front();
					if (m_tdata[2:0] !== want.state)
						flag_mismatch("parse_state", m_tdata[2:0], want.state);
					if (m_tdata[12:3] !== want.code)
						flag_mismatch("resp_code", m_tdata[12:3], want.code);
					if (m_tdata[44:13] !== want.content_len)
						flag_mismatch("content_length", m_tdata[44:13], want.content_len);
					if (m_tdata[60:45] !== want.hdr_bytes)
						flag_mismatch("header_length", m_tdata[60:45], want.hdr_bytes);
					if (m_tdata[63:61] !== 3'd0)
						flag_mismatch("tdata padding", m_tdata[63:61], '0);
					if (m_tuser[0] !== want.body)
						flag_mismatch("body_byte", m_tuser[0], want.body);
				end
			end
		end
	end

	// Stall the result side at random
	always @(posedge clk)
		m_tready <= no_idle || ($urandom_range(0, 99) >= 38);

	// Bound the run
	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("tb: failure");
		$finish;
	end

	function automatic void add_text(string s);
		for (int i = 0; i < s.len(); i++) stream_q.push_back(s[i]);
	endfunction

	function automatic void add_digits(int n);
		repeat (n) stream_q.push_back(8'(CH_ZERO + $urandom_range(0, 9)));
	endfunction

	function automatic void add_letters(int n);
		repeat (n) stream_q.push_back(8'($urandom_range(65, 90) + ($urandom_range(0, 1) ? 32 : 0)));
	endfunction

	// Send one request, idling before it at random
	task automatic send_request(logic [7:0] b, logic first);
		int gap;
		gap = 0;
		if (!no_idle)
			while (gap < 20 && $urandom_range(0, 99) < 38) gap++;
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= b;
		s_tuser  <= first;
		do @(posedge clk); while (!s_tready);
	endtask

	task automatic send_stream(logic fresh);
		for (int i = 0; i < stream_q.size(); i++) send_request(stream_q[i], fresh && i == 0);
		stream_q.delete();
	endtask

	// Drop valid and wait until every report has come back
	task automatic wait_quiet();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending_reports.size() != 0) @(posedge clk);
	endtask

	task automatic write_accepted(logic [9:0] v);
		wait_quiet();
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= v;
		@(posedge clk);
		cfg_wr_en     <= 1'b0;
		accepted_code  = v;
	endtask

	task automatic test_status_line_cases();
		// space as the very first byte, then a byte in the terminal state
		add_text(" x");
		send_stream(1'b1);
		// four code characters
		add_text("H 2000");
		send_stream(1'b1);
		// two code characters
		add_text("H 20 ");
		send_stream(1'b1);
		// blank line while still on the status line
		add_text("\015\012\015\012");
		send_stream(1'b1);
		// letters cut the code short, so the code is not accepted
		add_text("H 2a9 \015\012");
		send_stream(1'b1);
		// byte extremes in the first word, header without any length line
		stream_q.push_back(8'hFF);
		stream_q.push_back(8'h00);
		add_text(" 200 \015\012\015\012");
		send_stream(1'b1);
	endtask

	task automatic test_length_lines();
		// length name on the status line itself, then a body byte
		add_text("Content-Length 200 \015\012\015\012Z");
		send_stream(1'b1);
		// name without a value, then a later line that saturates
		add_text("H 200 \015\012content-length\015\012");
		add_text("Content-Length: 4294967296\015\012\015\012X");
		send_stream(1'b1);
		// new response in the middle of a status line
		add_text("H 20");
		send_stream(1'b1);
		add_text("H 200 \015\012CONTENT-LENGTH:0\015\012\015\012");
		send_stream(1'b1);
	endtask

	task automatic test_config_extremes();
		write_accepted(10'd100);
		add_text("H 100 \015\012Content-Length: 1\015\012\015\012");
		send_stream(1'b1);
		add_text("H 999 ");
		send_stream(1'b1);
		write_accepted(10'd999);
		add_text("H 999 \015\012content-length:9\015\012\015\012");
		send_stream(1'b1);
		add_text("H 100 ");
		send_stream(1'b1);
		write_accepted(ACCEPTED_STATUS_RESET);
	endtask

	// Long header sent back to back, with both sides never idling
	task automatic test_long_header();
		no_idle = 1'b1;
		add_text("H 200 \015\012");
		repeat (2) begin
			add_text("X-Pad: ");
			repeat (91) stream_q.push_back(8'h61);
			add_text("\015\012");
		end
		add_text("content-length: 12\015\012\015\012B");
		send_stream(1'b1);
		wait_quiet();
		no_idle = 1'b0;
	endtask

	task automatic test_random_responses();
		int sent;
		int resp;
		int kind;
		sent = 0;
		resp = 0;
		while (sent < RANDOM_BYTES) begin
			// change the accepted code between responses now and then
			if (resp % 10 == 9) begin
				case ($urandom_range(0, 3))
					0: write_accepted(10'd100);
					1: write_accepted(10'd999);
					default: write_accepted(10'($urandom_range(100, 999)));
				endcase
			end
			kind = $urandom_range(0, 9);
			if (kind == 0) begin
				// noise with plenty of line and space bytes
				repeat ($urandom_range(1, 24)) begin
					case ($urandom_range(0, 5))
						0: stream_q.push_back(CH_CR);
						1: stream_q.push_back(CH_LF);
						2: stream_q.push_back(CH_SPACE);
						default: stream_q.push_back(8'($urandom_range(0, 255)));
					endcase
				end
			end else begin
				// status line, broken in a few ways or well formed
				if (kind == 1) begin
					case ($urandom_range(0, 4))
						0: add_text(" HTTP/1.1 200 ");
						1: begin
							add_text("H ");
							add_digits($urandom_range(0, 2));
							add_text(" \015\012\015\012");
						end
						2: begin
							add_text("H ");
							add_digits(4);
						end
						3: add_text("HTTP/1.1\015\012\015\012");
						default: begin
							add_text("H ");
							add_letters(1);
							add_digits(2);
							add_text(" \015\012");
						end
					endcase
				end else begin
					add_text($urandom_range(0, 1) ? "HTTP/1.1 " : "H ");
					case ($urandom_range(0, 9))
						0, 1, 2, 3, 4, 5: add_text($sformatf("%0d", accepted_code));
						6, 7: add_text($sformatf("%0d", $urandom_range(100, 999)));
						8: add_text($sformatf("%03d", $urandom_range(0, 999)));
						default: begin
							add_digits(1);
							add_letters(2);
						end
					endcase
					add_text(" ");
					add_letters($urandom_range(0, 6));
					add_text("\015\012");
				end
				// header lines
				repeat ($urandom_range(0, 4)) begin
					case ($urandom_range(0, 5))
						0, 1, 2: begin
							add_text(length_names[$urandom_range(0, 2)]);
							case ($urandom_range(0, 4))
								0: add_text("");
								1: add_text(":");
								2: add_text(": ");
								3: add_text(" : ");
								default: add_text(":: ");
							endcase
							case ($urandom_range(0, 5))
								0: add_text("");
								1: add_text("4294967295");
								2: add_text("4294967296");
								3: add_digits($urandom_range(11, 14));
								default: add_digits($urandom_range(1, 6));
							endcase
							if ($urandom_range(0, 3) == 0) add_text(" x");
						end
						3: begin
							add_text(other_names[$urandom_range(0, 3)]);
							add_text(": ");
							add_letters($urandom_range(0, 8));
						end
						4: add_text($urandom_range(0, 1) ? "Content-Lengt: 5" : "content-lengthy: 3");
						default: begin
							case ($urandom_range(0, 3))
								0: add_text("\015");
								1: add_text("\012");
								2: add_text("\015\015");
								default: add_text("X\012");
							endcase
						end
					endcase
					add_text("\015\012");
				end
				// blank line, left out now and then
				if ($urandom_range(0, 9) != 0) add_text("\015\012");
				repeat ($urandom_range(0, 3)) stream_q.push_back(8'($urandom_range(0, 255)));
			end
			sent += stream_q.size();
			send_stream($urandom_range(0, 19) != 0);
			resp++;
		end
	endtask

	initial begin
		clear_parser();
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_status_line_cases();
		test_length_lines();
		test_config_extremes();
		test_long_header();
		test_random_responses();
		wait_quiet();
		repeat (10) @(posedge clk);
		if (mismatch_count == 0) $display("tb: success");
		else $display("tb: failure");
		$finish;
	end

endmodule
